// ===== src/serial_frame_sync_xor_check_core_defines.svh =====
// Assertion macros shared by the frame sync core.
`ifndef SERIAL_FRAME_SYNC_XOR_CHECK_CORE_DEFINES_SVH
`define SERIAL_FRAME_SYNC_XOR_CHECK_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define SFSX_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define SFSX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sfsx_pkg.sv =====
`timescale 1ns / 1ps

package sfsx_pkg;

  // Default window length in bytes.
  localparam int FRAME_BYTES_DEF = 23;

  localparam int BYTE_W = 8;
  localparam int WORD_W = 32;

  // Frame markers.
  localparam logic [BYTE_W-1:0] SYNC_HEAD = 8'h40;
  localparam logic [BYTE_W-1:0] SYNC_TAIL = 8'h2B;

  // Frame status for the window as it stands after the current transfer.
  typedef struct packed {
    logic marks_ok;  // head and tail markers in place
    logic csum_ok;   // seeded XOR matches the received checksum byte
  } frame_stat_t;

endpackage

// ===== src/sfsx_cell.sv =====
`timescale 1ns / 1ps

// One byte of the window: loads its neighbour's byte on each shift.
module sfsx_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         shift_en,
  input  logic [sfsx_pkg::BYTE_W-1:0]  d_in,
  output logic [sfsx_pkg::BYTE_W-1:0]  q
);

  logic [sfsx_pkg::BYTE_W-1:0] byte_r;
  logic [sfsx_pkg::BYTE_W-1:0] byte_nxt;

  // Take the neighbour's byte on a shift, else hold.
  always_comb begin
    byte_nxt = shift_en ? d_in : byte_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  assign q = byte_r;

endmodule

// ===== src/sfsx_window.sv =====
`timescale 1ns / 1ps

// Sliding byte window built as a chain of cells, with a running XOR of
// cells 3 to the end and the frame status for the window after this shift.
module sfsx_window #(
  parameter int FRAME_BYTES = sfsx_pkg::FRAME_BYTES_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          shift_en,
  input  logic [sfsx_pkg::BYTE_W-1:0]                   rx_byte,
  input  logic [sfsx_pkg::BYTE_W-1:0]                   seed,
  output logic [FRAME_BYTES-1:0][sfsx_pkg::BYTE_W-1:0]  taps,
  output sfsx_pkg::frame_stat_t                         stat
);

  logic [sfsx_pkg::BYTE_W-1:0] acc_r;
  logic [sfsx_pkg::BYTE_W-1:0] acc_nxt;

  // Chain: each cell takes the byte of the cell above, the last takes rx_byte.
  for (genvar i = 0; i < FRAME_BYTES; i++) begin : g_cell
    logic [sfsx_pkg::BYTE_W-1:0] d_in;
    if (i == FRAME_BYTES - 1) begin : g_last
      assign d_in = rx_byte;
    end else begin : g_mid
      assign d_in = taps[i+1];
    end
    sfsx_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .d_in     (d_in),
      .q        (taps[i])
    );
  end

  // Running XOR: add the new byte, drop the one leaving position 3.
  always_comb begin
    acc_nxt = shift_en ? (acc_r ^ rx_byte ^ taps[3]) : acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  // Status of the shifted window: old cell 1 becomes the head, old cell 2
  // the checksum, the new byte the tail.
  always_comb begin
    stat.marks_ok = (taps[1] == sfsx_pkg::SYNC_HEAD) && (rx_byte == sfsx_pkg::SYNC_TAIL);
    stat.csum_ok  = ((seed ^ acc_r ^ rx_byte ^ taps[3]) == taps[2]);
  end

endmodule

// ===== src/serial_frame_sync_xor_check_core.sv =====
`timescale 1ns / 1ps

`include "serial_frame_sync_xor_check_core_defines.svh"

// Serial frame synchroniser: takes one received byte per transfer into a
// FRAME_BYTES long window (a chain of byte cells) and, once the window is
// full and framed by '@' ... '+', delivers one result checked against the
// seeded XOR of bytes 3 to the end. A byte is taken every cycle: the window
// shift, the running XOR and the result evaluation all complete in the
// cycle of the transfer, and the result lands in a single output register.
// The input stalls only while that register holds a result and out_ready is
// low. A result appears on the output the cycle after the byte that
// completes the frame; on a checksum mismatch the word fields read zero.
module serial_frame_sync_xor_check_core #(
  parameter int FRAME_BYTES = sfsx_pkg::FRAME_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sfsx_pkg::BYTE_W-1:0]         cfg_checksum_seed,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [sfsx_pkg::BYTE_W-1:0]         in_rx_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_checksum_error,
  output logic [sfsx_pkg::WORD_W-1:0]         out_roll_word,
  output logic [sfsx_pkg::WORD_W-1:0]         out_pitch_word,
  output logic [sfsx_pkg::WORD_W-1:0]         out_yaw_word,
  output logic [sfsx_pkg::WORD_W-1:0]         out_throttle_word,
  output logic signed [sfsx_pkg::WORD_W-1:0]  out_mode_word
);

  localparam int FILL_W = $clog2(FRAME_BYTES + 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(FRAME_BYTES);
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(FRAME_BYTES - 1);

  logic [sfsx_pkg::BYTE_W-1:0]                  seed_r;
  logic [sfsx_pkg::BYTE_W-1:0]                  seed_nxt;
  logic [FILL_W-1:0]                            fill_r;
  logic [FILL_W-1:0]                            fill_nxt;
  logic                                         out_valid_r;
  logic                                         out_valid_nxt;
  logic                                         err_r;
  logic [sfsx_pkg::WORD_W-1:0]                  roll_r;
  logic [sfsx_pkg::WORD_W-1:0]                  pitch_r;
  logic [sfsx_pkg::WORD_W-1:0]                  yaw_r;
  logic [sfsx_pkg::WORD_W-1:0]                  throttle_r;
  logic [sfsx_pkg::WORD_W-1:0]                  mode_r;
  logic                                         in_xfer;
  logic                                         full_nxt;
  logic                                         hit;
  logic [FRAME_BYTES-1:0][sfsx_pkg::BYTE_W-1:0] taps;
  sfsx_pkg::frame_stat_t                        stat;

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  // Seed register.
  always_comb begin
    seed_nxt = cfg_we ? cfg_checksum_seed : seed_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else begin
      seed_r <= seed_nxt;
    end
  end

  sfsx_window #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (in_xfer),
    .rx_byte  (in_rx_byte),
    .seed     (seed_r),
    .taps     (taps),
    .stat     (stat)
  );

  // Fill count, saturating at the window length.
  always_comb begin
    fill_nxt = fill_r;
    if (in_xfer && (fill_r != FILL_FULL)) begin
      fill_nxt = fill_r + FILL_W'(1);
    end
  end

  assign full_nxt = (fill_r >= FILL_LAST);
  assign hit      = in_xfer && full_nxt && stat.marks_ok;

  // Result slot: fill on a framed byte, drain on an output transfer.
  always_comb begin
    priority if (hit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the payload; words come from the window after this shift (old
  // cell p+1 becomes cell p), zero on a checksum mismatch.
  always_ff @(posedge clk) begin
    if (hit) begin
      err_r <= !stat.csum_ok;
      if (stat.csum_ok) begin
        roll_r     <= {taps[6],  taps[5],  taps[4],  taps[3]};
        pitch_r    <= {taps[10], taps[9],  taps[8],  taps[7]};
        yaw_r      <= {taps[14], taps[13], taps[12], taps[11]};
        throttle_r <= {taps[18], taps[17], taps[16], taps[15]};
        mode_r     <= {taps[22], taps[21], taps[20], taps[19]};
      end else begin
        roll_r     <= '0;
        pitch_r    <= '0;
        yaw_r      <= '0;
        throttle_r <= '0;
        mode_r     <= '0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_checksum_error = err_r;
  assign out_roll_word      = roll_r;
  assign out_pitch_word     = pitch_r;
  assign out_yaw_word       = yaw_r;
  assign out_throttle_word  = throttle_r;
  assign out_mode_word      = $signed(mode_r);

  // Checks on the block's own logic.
  `SFSX_ASSERT_SAME(a_fill_bound, 1'b1, fill_r <= FILL_FULL, "fill count beyond window length")
  `SFSX_ASSERT_SAME(a_result_when_full, out_valid_r, fill_r == FILL_FULL, "result from a part-filled window")
  `SFSX_ASSERT_SAME(a_error_zero_words, out_valid_r && err_r, (roll_r == '0) && (pitch_r == '0) && (yaw_r == '0) && (throttle_r == '0) && (mode_r == '0), "error result with non-zero words")
  `SFSX_ASSERT_NEXT(a_hit_shows, hit, out_valid_r, "framed byte produced no result")

endmodule

// ===== tb/sv/sfsx_frame_checker.sv =====
`timescale 1ns / 1ps

module sfsx_frame_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [sfsx_pkg::BYTE_W-1:0]  cfg_checksum_seed,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [sfsx_pkg::BYTE_W-1:0]  in_rx_byte,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic                         out_checksum_error,
  input  logic [sfsx_pkg::WORD_W-1:0]  out_roll_word,
  input  logic [sfsx_pkg::WORD_W-1:0]  out_pitch_word,
  input  logic [sfsx_pkg::WORD_W-1:0]  out_yaw_word,
  input  logic [sfsx_pkg::WORD_W-1:0]  out_throttle_word,
  input  logic [sfsx_pkg::WORD_W-1:0]  out_mode_word,
  output int                           mismatches,
  output int                           frames_pending
);

  import sfsx_pkg::*;

  localparam int FB = FRAME_BYTES_DEF;

  typedef struct packed {
    logic              checksum_error;
    logic [WORD_W-1:0] roll;
    logic [WORD_W-1:0] pitch;
    logic [WORD_W-1:0] yaw;
    logic [WORD_W-1:0] throttle;
    logic [WORD_W-1:0] mode;
  } frame_fields_t;

  // Mirror of the receive window and the checksum seed register
  logic [BYTE_W-1:0] win [FB];
  int                fill;
  logic [BYTE_W-1:0] seed;
  frame_fields_t     frames_due [$];

  function automatic logic [WORD_W-1:0] le_word(input int pos);
    return {win[pos+3], win[pos+2], win[pos+1], win[pos]};
  endfunction

  // Shift one byte into the window and queue the frame it completes, if any
  task automatic absorb_rx_byte(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] sum;
    frame_fields_t     res;
    if (fill >= FB) begin
      for (int i = 0; i < FB - 1; i++) win[i] = win[i+1];
      win[FB-1] = b;
    end else begin
      win[fill] = b;
      fill++;
    end
    if (fill < FB || win[0] != SYNC_HEAD || win[FB-1] != SYNC_TAIL) return;
    sum = seed;
    for (int i = 3; i < FB; i++) sum ^= win[i];
    res = '0;
    if (sum != win[1]) begin
      res.checksum_error = 1'b1;
    end else begin
      res.roll     = le_word(2);
      res.pitch    = le_word(6);
      res.yaw      = le_word(10);
      res.throttle = le_word(14);
      res.mode     = le_word(18);
    end
    frames_due.insert(frames_due.size(), res);
  endtask

  function automatic void check_field(input string what, input logic [WORD_W-1:0] want,
                                      input logic [WORD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    frame_fields_t want;
    if (!rst_n) begin
      for (int i = 0; i < FB; i++) win[i] = '0;
      fill = 0;
      seed = '0;
      mismatches = 0;
      frames_due.delete();
    end else begin
      // Compare a result transfer against the oldest expected frame
      if (out_valid && out_ready) begin
        if (frames_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got err=%0b roll=%h mode=%h",
                   $time, out_checksum_error, out_roll_word, out_mode_word);
          mismatches++;
        end else begin
          want = frames_due.pop_front();
          check_field("checksum_error", want.checksum_error, out_checksum_error);
          check_field("roll_word", want.roll, out_roll_word);
          check_field("pitch_word", want.pitch, out_pitch_word);
          check_field("yaw_word", want.yaw, out_yaw_word);
          check_field("throttle_word", want.throttle, out_throttle_word);
          check_field("mode_word", want.mode, out_mode_word);
        end
      end
      if (cfg_we) seed = cfg_checksum_seed;
      if (in_valid && in_ready) absorb_rx_byte(in_rx_byte);
    end
    frames_pending = frames_due.size();
  end

endmodule

// ===== tb/sv/serial_frame_sync_xor_check_core_test.sv =====
`timescale 1ns / 1ps

module serial_frame_sync_xor_check_core_test;

  import sfsx_pkg::*;

  localparam int FB = FRAME_BYTES_DEF;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [BYTE_W-1:0] cfg_checksum_seed = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] in_rx_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_checksum_error;
  logic [WORD_W-1:0] out_roll_word;
  logic [WORD_W-1:0] out_pitch_word;
  logic [WORD_W-1:0] out_yaw_word;
  logic [WORD_W-1:0] out_throttle_word;
  logic signed [WORD_W-1:0] out_mode_word;

  int                mismatches;
  int                frames_pending;
  int                items_sent = 0;
  bit                calm_tx = 1'b0;
  logic [BYTE_W-1:0] seed_now = '0;

  serial_frame_sync_xor_check_core u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_checksum_seed  (cfg_checksum_seed),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_checksum_error (out_checksum_error),
    .out_roll_word      (out_roll_word),
    .out_pitch_word     (out_pitch_word),
    .out_yaw_word       (out_yaw_word),
    .out_throttle_word  (out_throttle_word),
    .out_mode_word      (out_mode_word)
  );

  sfsx_frame_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_checksum_seed  (cfg_checksum_seed),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_checksum_error (out_checksum_error),
    .out_roll_word      (out_roll_word),
    .out_pitch_word     (out_pitch_word),
    .out_yaw_word       (out_yaw_word),
    .out_throttle_word  (out_throttle_word),
    .out_mode_word      (out_mode_word),
    .mismatches         (mismatches),
    .frames_pending     (frames_pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Random byte, biased towards the markers and the extremes
  function automatic logic [BYTE_W-1:0] payload_byte();
    case ($urandom_range(0, 15))
      0:       return SYNC_HEAD;
      1:       return SYNC_TAIL;
      2:       return 8'h00;
      3:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one byte and hold it until the transfer; called at a falling edge
  task automatic push_byte(input logic [BYTE_W-1:0] b);
    int gap;
    in_rx_byte <= b;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    gap = calm_tx ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Build a framed packet; optionally spoil the checksum or cut it short
  task automatic send_frame(input bit corrupt, input bit cut);
    logic [BYTE_W-1:0] fr [FB];
    int                n;
    fr[0]    = SYNC_HEAD;
    fr[FB-1] = SYNC_TAIL;
    for (int i = 2; i < FB - 1; i++) fr[i] = payload_byte();
    fr[1] = seed_now;
    for (int i = 3; i < FB; i++) fr[1] ^= fr[i];
    if (corrupt) fr[1] ^= 8'($urandom_range(1, 255));
    n = cut ? $urandom_range(2, FB - 2) : FB;
    for (int i = 0; i < n; i++) push_byte(fr[i]);
  endtask

  // Drop valid, drain every expected frame, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (frames_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_seed(input logic [BYTE_W-1:0] v);
    cfg_checksum_seed <= v;
    cfg_we            <= 1'b1;
    @(negedge clk);
    cfg_we   <= 1'b0;
    seed_now = v;
  endtask

  // Result side: random stalls, calm stretches and two long hold-offs
  initial begin
    int stall, hold, taken, calm;
    stall = 0;
    hold  = 0;
    taken = 0;
    calm  = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        taken++;
        if (taken == 12 || taken == 30) hold = 300;
      end
      @(negedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else if (calm > 0) begin
        out_ready <= 1'b1;
        calm--;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 19) == 0) calm = $urandom_range(50, 150);
        else stall = pick_gap();
      end
    end
  end

  initial begin
    logic [BYTE_W-1:0] dir [FB+1];
    logic [BYTE_W-1:0] seeds [4];
    int                start_items, n_frames, r;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed frame at the reset seed: a tail marker lands while the window
    // is still filling, words hit all-ones, zero and the most negative mode.
    // The checksum byte doubles as a head marker, so one more tail byte
    // slides the window onto a second frame whose checksum fails.
    dir[0] = SYNC_HEAD;
    dir[1] = SYNC_HEAD;
    dir[2] = SYNC_TAIL;
    for (int i = 4; i < 6; i++) dir[i] = 8'hFF;
    for (int i = 6; i < 10; i++) dir[i] = 8'h00;
    for (int i = 10; i < 14; i++) dir[i] = 8'hFF;
    for (int i = 14; i < 21; i++) dir[i] = 8'h00;
    dir[21] = 8'h80;
    dir[22] = SYNC_TAIL;
    dir[23] = SYNC_TAIL;
    dir[3]  = SYNC_HEAD ^ seed_now;
    for (int i = 4; i < FB; i++) dir[3] ^= dir[i];
    for (int i = 0; i < FB + 1; i++) push_byte(dir[i]);

    // Random phases, one seed each; the second phase sends back to back
    seeds[0] = 8'hFF;
    seeds[1] = 8'h00;
    seeds[2] = 8'($urandom_range(1, 254));
    seeds[3] = 8'($urandom_range(0, 255));
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      write_seed(seeds[p]);
      calm_tx     = (p == 1);
      start_items = items_sent;
      n_frames    = 0;
      while (items_sent - start_items < 125 || n_frames < 9) begin
        r = $urandom_range(0, 9);
        if (r < 7) begin
          send_frame(1'b0, 1'b0);
          n_frames++;
        end else if (r == 7) begin
          send_frame(1'b1, 1'b0);
          n_frames++;
        end else if (r == 8) begin
          send_frame(1'b0, 1'b1);
        end else begin
          repeat ($urandom_range(1, 5)) push_byte(payload_byte());
        end
      end
    end

    wait_idle();
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== serial_frame_sync_xor_check_core.f =====
+incdir+src
src/sfsx_pkg.sv
src/sfsx_cell.sv
src/sfsx_window.sv
src/serial_frame_sync_xor_check_core.sv
tb/sv/sfsx_frame_checker.sv
tb/sv/serial_frame_sync_xor_check_core_test.sv
